[hdl/tcw_pkg.sv]
// Package for the text console writer: screen geometry, character codes,
// beat payload types, memory request type and controller states.
// No dependencies.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int SCAN_W     = $clog2(CELL_COUNT + 1);
  localparam int CELL_W     = 16;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h1F;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;

  typedef enum logic [1:0] {
    ACT_PUT        = 2'd0,
    ACT_SET_CURSOR = 2'd1,
    ACT_CLEAR      = 2'd2,
    ACT_READ       = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [7:0] color;
    logic [6:0] pos_x;
    logic [4:0] pos_y;
  } tcw_cmd_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [7:0]  attribute;
    logic [15:0] cell_data;
  } tcw_rsp_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } tcw_ram_req_t;

endpackage

[hdl/text_console_writer.sv]
// Text console writer top level: cursor control and screen memory sequencer.
// The screen memory has one read port and one write port, and scroll and clear
// sweeps handle one cell per cycle. One command beat in flight. Reset clears
// the cursor to (0,0) and sets the attribute to 0x1F; the screen memory is not
// initialized. Depends on tcw_pkg and tcw_screen_ram.
module text_console_writer (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  tcw_pkg::tcw_cmd_t cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output tcw_pkg::tcw_rsp_t rsp
);

  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int SCAN_W = tcw_pkg::SCAN_W;
  localparam int CELL_W = tcw_pkg::CELL_W;

  tcw_pkg::state_t state, state_next;

  logic [COL_W-1:0]  col_reg, col_next;
  logic [ROW_W-1:0]  row_reg, row_next;
  logic [7:0]        attr_reg, attr_next;
  logic [7:0]        color_hold, color_next;
  logic [SCAN_W-1:0] scan, scan_next;
  logic              load_rsp;
  logic [CELL_W-1:0] cell_next;

  tcw_pkg::tcw_ram_req_t ram_req;
  logic [CELL_W-1:0]     rd_data;

  logic              accept;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] read_addr;
  logic [COL_W-1:0]  clamp_col;
  logic [ROW_W-1:0]  clamp_row;
  logic [COL_W:0]    col_inc;
  logic [COL_W-1:0]  put_col;
  logic [ROW_W:0]    put_row_w;
  logic [ROW_W-1:0]  put_row;
  logic              put_write;
  logic              need_scroll;
  logic              sweep_last;

  tcw_screen_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  assign cmd_stall = (state != tcw_pkg::ST_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = cmd_valid && !cmd_stall;

  assign cur_addr  = ADDR_W'(int'(row_reg) * tcw_pkg::COLUMNS + int'(col_reg));
  assign clamp_col = (int'(cmd.pos_x) >= tcw_pkg::COLUMNS) ?
                     COL_W'(tcw_pkg::COLUMNS - 1) : COL_W'(cmd.pos_x);
  assign clamp_row = (int'(cmd.pos_y) >= tcw_pkg::ROWS) ?
                     ROW_W'(tcw_pkg::ROWS - 1) : ROW_W'(cmd.pos_y);
  assign read_addr = ADDR_W'(int'(clamp_row) * tcw_pkg::COLUMNS + int'(clamp_col));
  assign col_inc   = {1'b0, col_reg} + (COL_W + 1)'(1);
  assign sweep_last = (scan == SCAN_W'(tcw_pkg::CELL_COUNT - 1));

  // Cursor movement for a put character beat.
  always_comb begin
    put_col   = col_reg;
    put_row_w = {1'b0, row_reg};
    put_write = 1'b0;
    if (cmd.char_code == tcw_pkg::CH_NEWLINE) begin
      put_col   = '0;
      put_row_w = {1'b0, row_reg} + (ROW_W + 1)'(1);
    end else if (cmd.char_code == tcw_pkg::CH_RETURN) begin
      put_col = '0;
    end else begin
      put_write = 1'b1;
      if (col_inc == (COL_W + 1)'(tcw_pkg::COLUMNS)) begin
        put_col   = '0;
        put_row_w = {1'b0, row_reg} + (ROW_W + 1)'(1);
      end else begin
        put_col = col_inc[COL_W-1:0];
      end
    end
    need_scroll = (put_row_w == (ROW_W + 1)'(tcw_pkg::ROWS));
    put_row     = need_scroll ? ROW_W'(tcw_pkg::ROWS - 1) : put_row_w[ROW_W-1:0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd.action)
            tcw_pkg::ACT_PUT:        state_next = need_scroll ? tcw_pkg::ST_SCROLL
                                                              : tcw_pkg::ST_IDLE;
            tcw_pkg::ACT_SET_CURSOR: state_next = tcw_pkg::ST_IDLE;
            tcw_pkg::ACT_CLEAR:      state_next = tcw_pkg::ST_CLEAR;
            tcw_pkg::ACT_READ:       state_next = tcw_pkg::ST_READ;
            default:                 state_next = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_READ: state_next = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_SCROLL: begin
        if (scan == SCAN_W'(tcw_pkg::CELL_COUNT)) begin
          state_next = tcw_pkg::ST_BLANK;
        end
      end
      tcw_pkg::ST_BLANK, tcw_pkg::ST_CLEAR: begin
        if (sweep_last) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory requests.
  always_comb begin
    col_next   = col_reg;
    row_next   = row_reg;
    attr_next  = attr_reg;
    color_next = color_hold;
    scan_next  = scan;
    load_rsp   = 1'b0;
    cell_next  = '0;
    ram_req    = '0;
    unique case (state)
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          color_next = cmd.color;
          unique case (cmd.action)
            tcw_pkg::ACT_PUT: begin
              ram_req.wr_en   = put_write;
              ram_req.wr_addr = cur_addr;
              ram_req.wr_data = {cmd.color, cmd.char_code};
              col_next        = put_col;
              row_next        = put_row;
              if (need_scroll) begin
                scan_next = SCAN_W'(tcw_pkg::COLUMNS);
              end else begin
                load_rsp = 1'b1;
              end
            end
            tcw_pkg::ACT_SET_CURSOR: begin
              col_next = clamp_col;
              row_next = clamp_row;
              load_rsp = 1'b1;
            end
            tcw_pkg::ACT_CLEAR: begin
              col_next  = '0;
              row_next  = '0;
              attr_next = cmd.color;
              scan_next = '0;
            end
            tcw_pkg::ACT_READ: begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = read_addr;
            end
            default: ;
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        load_rsp  = 1'b1;
        cell_next = rd_data;
      end
      tcw_pkg::ST_SCROLL: begin
        // Read one row down and write back the cell read in the previous cycle.
        ram_req.rd_en   = (scan != SCAN_W'(tcw_pkg::CELL_COUNT));
        ram_req.rd_addr = scan[ADDR_W-1:0];
        ram_req.wr_en   = (scan != SCAN_W'(tcw_pkg::COLUMNS));
        ram_req.wr_addr = ADDR_W'(int'(scan) - tcw_pkg::COLUMNS - 1);
        ram_req.wr_data = rd_data;
        if (scan == SCAN_W'(tcw_pkg::CELL_COUNT)) begin
          scan_next = SCAN_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
        end else begin
          scan_next = scan + SCAN_W'(1);
        end
      end
      tcw_pkg::ST_BLANK, tcw_pkg::ST_CLEAR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = scan[ADDR_W-1:0];
        ram_req.wr_data = {color_hold, tcw_pkg::BLANK_CHAR};
        if (sweep_last) begin
          load_rsp = 1'b1;
        end else begin
          scan_next = scan + SCAN_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::ST_IDLE;
      col_reg   <= '0;
      row_reg   <= '0;
      attr_reg  <= tcw_pkg::RESET_ATTR;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      col_reg  <= col_next;
      row_reg  <= row_next;
      attr_reg <= attr_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    color_hold <= color_next;
    scan       <= scan_next;
    if (load_rsp) begin
      rsp.cursor_col <= 7'(col_next);
      rsp.cursor_row <= 5'(row_next);
      rsp.attribute  <= attr_next;
      rsp.cell_data  <= cell_next;
    end
  end

endmodule

[hdl/tcw_screen_ram.sv]
// Screen cell memory: one write port and one read port, registered read data.
// Depends on tcw_pkg.
module tcw_screen_ram (
  input  logic                        clk,
  input  tcw_pkg::tcw_ram_req_t       req,
  output logic [tcw_pkg::CELL_W-1:0]  rd_data
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
